// ===== hw/rtl/ssmq_pkg.sv =====
`timescale 1ns / 1ps
package ssmq_pkg;
  localparam int SLOTS = 16;
  localparam int RANKS = 8;
  localparam int MAX_LENGTH = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int RANK_W = $clog2(RANKS);
  localparam int CNT_W = 5;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOTS);

  localparam logic [0:0] CFG_ACTIVE_RANKS = 1'b0;
  localparam logic [0:0] CFG_SENDER_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_LIMIT     = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_RANK  = 3'd4
  } status_t;

  typedef struct packed {
    logic        op;
    logic [2:0]  requester;
    logic [2:0]  dest;
    logic [10:0] msg_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [2:0]  source;
    logic [10:0] length;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        bad;
    logic        op;
    logic [RANK_W-1:0] req;
    logic [RANK_W-1:0] dst;
    logic [10:0] len;
  } cmd_t;
endpackage

// ===== hw/rtl/ssmq_front.sv =====
`timescale 1ns / 1ps
module ssmq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  ssmq_pkg::in_item_t in_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [4:0]        cfg_data,
  output logic [4:0]        limit,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output ssmq_pkg::cmd_t    cmd
);
  import ssmq_pkg::*;

  logic [3:0] active_r;
  logic [4:0] limit_r;
  cmd_t       q_r [2];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic       push_ok, req_ok, dst_ok;

  assign cfg_ready = 1'b1;
  assign limit = limit_r;
  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  always_comb begin
    req_ok = ({1'b0, in_item.requester} < active_r) && (32'(in_item.requester) < RANKS);
    dst_ok = ({1'b0, in_item.dest} < active_r) && (32'(in_item.dest) < RANKS);
    c.bad = !req_ok || (!in_item.op && !dst_ok);
    c.op  = in_item.op;
    c.req = RANK_W'(in_item.requester);
    c.dst = RANK_W'(in_item.dest);
    c.len = (in_item.msg_length > 11'(MAX_LENGTH)) ? 11'(MAX_LENGTH) : in_item.msg_length;
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= c;
    if (!rst_n) begin
      active_r <= 4'd8;
      limit_r  <= 5'd16;
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_ACTIVE_RANKS) active_r <= cfg_data[3:0];
        else limit_r <= cfg_data;
      end
      if (push_ok) wp_r <= wp_r + 1'b1;
      if (cmd_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, cmd_take};
    end
  end
endmodule

// ===== hw/rtl/ssmq_back.sv =====
`timescale 1ns / 1ps
module ssmq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  ssmq_pkg::cmd_t     cmd,
  input  logic [4:0]         limit,
  output logic               out_empty,
  input  logic               out_pop,
  output ssmq_pkg::out_item_t out_item
);
  import ssmq_pkg::*;

  logic [LINK_W-1:0] nxt_r [SLOTS];
  logic [2:0]        src_r [SLOTS];
  logic [10:0]       len_r [SLOTS];
  logic [LINK_W-1:0] fh_r;
  logic [LINK_W-1:0] mh_r [RANKS];
  logic [LINK_W-1:0] mt_r [RANKS];
  logic [CNT_W-1:0]  oc_r [RANKS];
  out_item_t         res_r;
  logic              full_r;
  out_item_t         r;
  logic [SLOT_W-1:0] s, t;
  logic [RANK_W-1:0] sr;
  logic              do_send, do_recv;

  assign out_empty = !full_r;
  assign out_item = res_r;
  assign cmd_take = cmd_valid && (!full_r || out_pop);

  always_comb begin
    r = '0;
    do_send = 1'b0;
    do_recv = 1'b0;
    s = '0;
    t = SLOT_W'(mt_r[cmd.dst]);
    sr = '0;
    if (cmd.bad) r.status = ST_BAD_RANK;
    else if (!cmd.op) begin
      if (oc_r[cmd.req] >= limit) r.status = ST_LIMIT;
      else if (fh_r == LINK_NULL) r.status = ST_NO_SLOT;
      else begin
        do_send = 1'b1;
        s = SLOT_W'(fh_r);
        r.slot = 4'(s);
      end
    end else begin
      if (mh_r[cmd.req] == LINK_NULL) r.status = ST_EMPTY;
      else begin
        do_recv = 1'b1;
        s = SLOT_W'(mh_r[cmd.req]);
        sr = RANK_W'(src_r[s]);
        r.slot = 4'(s);
        r.source = src_r[s];
        r.length = len_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) res_r <= r;
    if (!rst_n) begin
      full_r <= 1'b0;
      fh_r <= '0;
      for (int i = 0; i < SLOTS; i++) nxt_r[i] <= LINK_W'(i + 1);
      for (int i = 0; i < RANKS; i++) begin
        mh_r[i] <= LINK_NULL; mt_r[i] <= LINK_NULL; oc_r[i] <= '0;
      end
    end else begin
      if (cmd_take) full_r <= 1'b1;
      else if (out_pop) full_r <= 1'b0;
      if (cmd_take && do_send) begin
        fh_r <= nxt_r[s];
        src_r[s] <= 3'(cmd.req);
        len_r[s] <= cmd.len;
        nxt_r[s] <= LINK_NULL;
        if (mt_r[cmd.dst] != LINK_NULL) nxt_r[t] <= LINK_W'(s);
        else mh_r[cmd.dst] <= LINK_W'(s);
        mt_r[cmd.dst] <= LINK_W'(s);
        oc_r[cmd.req] <= oc_r[cmd.req] + 1'b1;
      end
      if (cmd_take && do_recv) begin
        mh_r[cmd.req] <= nxt_r[s];
        if (nxt_r[s] == LINK_NULL) mt_r[cmd.req] <= LINK_NULL;
        nxt_r[s] <= fh_r;
        fh_r <= LINK_W'(s);
        if (oc_r[sr] != '0) oc_r[sr] <= oc_r[sr] - 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/shared_slot_mailbox_queue_manager.sv =====
`timescale 1ns / 1ps
// shared slot mailbox queue manager
// a pool of message slots shared by up to eight ranks: a free list plus a
// linked-list mailbox per destination rank.
// input channel: push/full, one request per transaction (send or receive).
// result channel: empty/pop, exactly one result per request, in order.
// config channel: cfg_valid/cfg_ready, always ready; index 0 active ranks,
// index 1 per-sender limit. write only while idle.
// the front checks ranks and clamps length into a two-entry command queue;
// the back walks the pointer tables combinationally for each command and
// registers its result into a one-entry result register.
// a request passes through the command queue, then its result is held in the result register.
// throughput: one request per cycle while results are popped every cycle;
// a stalled receiver holds the result, then the command queue fills and
// full rises after two more requests.
// reset: free list is the chain 0..15, mailboxes empty, counts zero,
// active ranks 8, limit 16; usable right after reset.
module shared_slot_mailbox_queue_manager (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  ssmq_pkg::in_item_t   in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output ssmq_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [4:0]           cfg_data
);
  import ssmq_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;
  logic [4:0] limit;

  ssmq_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .limit,
    .cmd_valid, .cmd_take, .cmd
  );

  ssmq_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
    .limit,
    .out_empty, .out_pop, .out_item
  );
endmodule
